### rtl/blm_pkg.sv
// Shared types and constants for the byte-lane data memory.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package blm_pkg;

  // Size codes as carried in size_code
  localparam logic [1:0] SIZE_WORD     = 2'b00;
  localparam logic [1:0] SIZE_BYTE     = 2'b01;
  localparam logic [1:0] SIZE_HALF     = 2'b10;
  localparam logic [1:0] SIZE_WORD_ALT = 2'b11;

  // Access kind
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        request;
    logic        cpu_reset;
    logic [31:0] byte_address;
    logic [1:0]  size_code;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        range_fault;
    logic        load_misaligned;
    logic        store_misaligned;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming word and decode it
    logic access;  // perform the memory read or write
    logic format;  // build the result word
  } dp_cmd_t;

endpackage

`default_nettype wire

### rtl/blm_ctrl.sv
// Sequencing controller for the byte-lane data memory.
// Depends on blm_pkg; drives the datapath command struct and both handshakes.
`default_nettype none

module blm_ctrl
  import blm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output dp_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_FORMAT,
    ST_HOLD
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;
  logic   access_r;
  logic   format_r;
  logic   accept;

  assign accept = in_valid & in_ready_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
      access_r    <= 1'b0;
      format_r    <= 1'b0;
    end else begin
      access_r <= 1'b0;
      format_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r    <= ST_ACCESS;
            in_ready_r <= 1'b0;
            access_r   <= 1'b1;
          end else begin
            in_ready_r <= 1'b1;
          end
        end
        ST_ACCESS: begin
          state_r  <= ST_FORMAT;
          format_r <= 1'b1;
        end
        ST_FORMAT: begin
          state_r     <= ST_HOLD;
          out_valid_r <= 1'b1;
        end
        ST_HOLD: begin
          // hold the result until it is taken
          if (out_ready) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b0;
            in_ready_r  <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready   = in_ready_r;
  assign out_valid  = out_valid_r;
  assign cmd.load   = accept;
  assign cmd.access = access_r;
  assign cmd.format = format_r;

endmodule

`default_nettype wire

### rtl/blm_dpath.sv
// Datapath of the byte-lane data memory: decode, fault checks, word store,
// lane extraction and merge. Depends on blm_pkg; steered by blm_ctrl.
`default_nettype none

module blm_dpath
  import blm_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  wire logic     clk,
  input  wire dp_cmd_t  cmd,
  input  wire in_item_t in_item,
  output out_item_t     out_item
);

  localparam int unsigned DEPTH = (MEM_BYTES + 3) / 4;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [32:0] MemLimit = 33'(MEM_BYTES);

  logic [31:0] mem [DEPTH];

  logic [IDX_W-1:0] idx_r;
  logic [1:0]       lane_r;
  logic             is_byte_r;
  logic             is_half_r;
  logic             kind_r;
  logic             go_r;
  logic             pf_r;
  logic             lmis_r;
  logic             smis_r;
  logic [31:0]      wdata_r;
  logic [31:0]      mem_q_r;
  logic             rd_hit_r;
  out_item_t        out_r;

  logic        is_byte;
  logic        is_half;
  logic        bad_align;
  logic        pf;
  logic        lmis;
  logic        smis;
  logic [4:0]  shift;
  logic [31:0] lane_mask;
  logic [3:0]  byte_en;
  logic [31:0] wdata_sh;
  logic [31:0] rd_lane;

  always_comb begin
    is_byte = (in_item.size_code == SIZE_BYTE);
    is_half = (in_item.size_code == SIZE_HALF);
    if (is_half) begin
      bad_align = in_item.byte_address[0];
    end else if (!is_byte) begin
      bad_align = (in_item.byte_address[1:0] != 2'b00);
    end else begin
      bad_align = 1'b0;
    end
    pf   = in_item.request & ({1'b0, in_item.byte_address} >= MemLimit);
    lmis = in_item.request & bad_align;
    smis = in_item.request & (in_item.kind == KIND_WRITE) & bad_align;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r     <= in_item.byte_address[IDX_W+1:2];
      lane_r    <= in_item.byte_address[1:0];
      is_byte_r <= is_byte;
      is_half_r <= is_half;
      kind_r    <= in_item.kind;
      wdata_r   <= in_item.write_data;
      pf_r      <= pf;
      lmis_r    <= lmis;
      smis_r    <= smis;
      go_r      <= in_item.request & ~in_item.cpu_reset & ~pf & ~lmis & ~smis;
    end
  end

  always_comb begin
    shift = {lane_r, 3'b000};
    if (is_byte_r) begin
      lane_mask = 32'h0000_00FF;
      byte_en   = 4'b0001 << lane_r;
    end else if (is_half_r) begin
      lane_mask = 32'h0000_FFFF;
      byte_en   = 4'b0011 << lane_r;
    end else begin
      lane_mask = 32'hFFFF_FFFF;
      byte_en   = 4'b1111;
    end
    wdata_sh = wdata_r << shift;
    rd_lane  = (mem_q_r >> shift) & lane_mask;
  end

  // Word store: byte-enabled write port, registered read port
  always_ff @(posedge clk) begin
    if (cmd.access && go_r) begin
      if (kind_r == KIND_WRITE) begin
        for (int i = 0; i < 4; i++) begin
          if (byte_en[i]) begin
            mem[idx_r][8*i +: 8] <= wdata_sh[8*i +: 8];
          end
        end
      end else begin
        mem_q_r <= mem[idx_r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      rd_hit_r <= go_r & (kind_r == KIND_READ);
    end
    if (cmd.format) begin
      out_r.read_data        <= rd_hit_r ? rd_lane : 32'h0000_0000;
      out_r.range_fault      <= pf_r;
      out_r.load_misaligned  <= lmis_r;
      out_r.store_misaligned <= smis_r;
    end
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

### rtl/byte_lane_data_memory_top.sv
// Top level of the byte-lane data memory: ties controller and datapath.
// Depends on blm_pkg, blm_ctrl and blm_dpath.
`default_nettype none

// Word-organised data memory of MEM_BYTES bytes with byte, halfword and word
// access. One word is taken on in_valid/in_ready, and its single result word
// appears on out_valid/out_ready. Each access runs in order from the accepting
// edge to result valid: the accepting edge captures the word and its fault
// decode, then the memory port does the read or byte-enabled write, then lane
// extraction loads the output register; the result is held until taken.
// in_ready is low during reset and rises in the cycle after reset is released.
// The next word is accepted the cycle after the result is taken, so the block
// takes no new word while one is in flight, paced by the single memory port
// and the sequencer.
// Words of the store are undefined until written; no clearing is done.
module byte_lane_data_memory_top
  import blm_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_item
);

  dp_cmd_t cmd;

  blm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  blm_dpath #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dpath (
    .clk      (clk),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

### tb/sv/byte_lane_data_memory_top_tb.sv
// Testbench for the byte-lane data memory: directed and random loads and stores
// checked against a behavioural image of the store. Depends on blm_pkg and
// byte_lane_data_memory_top.
`timescale 1ns / 1ps

module byte_lane_data_memory_top_tb;
  import blm_pkg::*;

  localparam int unsigned MEM_BYTES   = 65536;
  localparam int unsigned WORDS       = (MEM_BYTES + 3) / 4;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // Behavioural image of the store; a word counts as written once fully stored
  logic [31:0] mem_image [WORDS];
  bit          word_written [WORDS];

  out_item_t   expected_q [$];
  out_item_t   want;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned faults_seen = 0;

  byte_lane_data_memory_top #(.MEM_BYTES(MEM_BYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timed out with %0d results outstanding", $time, expected_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic misaligned(input logic [31:0] addr, input logic [1:0] size);
    case (size)
      SIZE_BYTE: return 1'b0;
      SIZE_HALF: return addr[0];
      default:   return addr[1:0] != 2'b00;
    endcase
  endfunction

  // Apply one access to the image and return the result it should produce
  function automatic out_item_t memory_access(input in_item_t a);
    out_item_t   r;
    logic        bad;
    logic [31:0] lane_mask;
    logic [31:0] old;
    int unsigned widx;
    int unsigned sh;
    r = '0;
    bad = misaligned(a.byte_address, a.size_code);
    if (a.request) begin
      r.range_fault      = (a.byte_address >= MEM_BYTES);
      r.load_misaligned  = bad;
      r.store_misaligned = bad && (a.kind == KIND_WRITE);
    end
    if (a.request && !a.cpu_reset && !r.range_fault && !bad) begin
      widx = a.byte_address >> 2;
      sh = 8 * int'(a.byte_address[1:0]);
      case (a.size_code)
        SIZE_BYTE: lane_mask = 32'h0000_00FF;
        SIZE_HALF: lane_mask = 32'h0000_FFFF;
        default:   lane_mask = 32'hFFFF_FFFF;
      endcase
      old = mem_image[widx];
      if (a.kind == KIND_WRITE) begin
        mem_image[widx] = (old & ~(lane_mask << sh)) | ((a.write_data << sh) & (lane_mask << sh));
        if (lane_mask == 32'hFFFF_FFFF) word_written[widx] = 1'b1;
      end else begin
        r.read_data = (old >> sh) & lane_mask;
      end
    end
    return r;
  endfunction

  function automatic in_item_t make_access(input logic kind, input logic request,
                                           input logic cpu_reset, input logic [31:0] addr,
                                           input logic [1:0] size, input logic [31:0] data);
    in_item_t a;
    a.kind         = kind;
    a.request      = request;
    a.cpu_reset    = cpu_reset;
    a.byte_address = addr;
    a.size_code    = size;
    a.write_data   = data;
    return a;
  endfunction

  // Mostly aligned accesses in a small window, with faulting and stray ones mixed in
  function automatic in_item_t random_access();
    in_item_t    a;
    int unsigned pick;
    int unsigned widx;
    logic [1:0]  lane;
    pick = $urandom_range(99);
    a.kind       = 1'($urandom_range(1));
    a.request    = ($urandom_range(99) < 92);
    a.cpu_reset  = ($urandom_range(99) < 6);
    a.size_code  = 2'($urandom_range(3));
    a.write_data = $urandom();
    if ($urandom_range(3) == 0) begin
      lane = 2'($urandom_range(3));
    end else begin
      case (a.size_code)
        SIZE_BYTE: lane = 2'($urandom_range(3));
        SIZE_HALF: lane = 2'($urandom_range(1)) << 1;
        default:   lane = 2'b00;
      endcase
    end
    if (pick < 10) begin
      a.byte_address = $urandom();
    end else if (pick < 20) begin
      a.byte_address = MEM_BYTES - 8 + $urandom_range(15);
    end else begin
      if ($urandom_range(3) == 0) widx = WORDS - 1 - $urandom_range(7);
      else widx = $urandom_range(31);
      a.byte_address = widx * 4 + lane;
    end
    // Turn a read or partial write of a never-written word into a full store
    if (a.request && !a.cpu_reset && a.byte_address < MEM_BYTES &&
        !misaligned(a.byte_address, a.size_code) && !word_written[a.byte_address >> 2] &&
        !(a.kind == KIND_WRITE && a.size_code != SIZE_BYTE && a.size_code != SIZE_HALF)) begin
      a.kind              = KIND_WRITE;
      a.size_code         = SIZE_WORD;
      a.byte_address[1:0] = 2'b00;
    end
    return a;
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken
  task automatic send_word(input in_item_t item);
    bit rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    expected_q.push_back(memory_access(item));
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
    end
  endtask

  // Inputs only move at rising edges, so the handshake is stable here
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, got %h", $time, out_item);
      end else begin
        want = expected_q.pop_front();
        report_field("read_data", want.read_data, out_item.read_data);
        report_field("range_fault", 32'(want.range_fault), 32'(out_item.range_fault));
        report_field("load_misaligned", 32'(want.load_misaligned),
                     32'(out_item.load_misaligned));
        report_field("store_misaligned", 32'(want.store_misaligned),
                     32'(out_item.store_misaligned));
        results_checked++;
        if (want.range_fault) faults_seen++;
      end
    end
  end

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(make_access(KIND_WRITE, 1'b1, 1'b0, 32'h0, SIZE_WORD, 32'hFFFF_FFFF));
    send_word(make_access(KIND_WRITE, 1'b1, 1'b0, 32'h4, SIZE_WORD_ALT, 32'h0));
    send_word(make_access(KIND_WRITE, 1'b1, 1'b0, 32'h8, SIZE_WORD, 32'h1234_5678));
    send_word(make_access(KIND_WRITE, 1'b1, 1'b0, MEM_BYTES - 4, SIZE_WORD, 32'hA5A5_5A5A));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'h0, SIZE_WORD, 32'hFFFF_FFFF));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'h4, SIZE_WORD_ALT, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'h8, SIZE_BYTE, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'h9, SIZE_BYTE, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'hA, SIZE_BYTE, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'hB, SIZE_BYTE, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'h8, SIZE_HALF, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'hA, SIZE_HALF, 32'h0));
    // partial stores must drop the upper bits of the data
    send_word(make_access(KIND_WRITE, 1'b1, 1'b0, 32'h9, SIZE_BYTE, 32'hFFFF_FFAB));
    send_word(make_access(KIND_WRITE, 1'b1, 1'b0, 32'hA, SIZE_HALF, 32'hFFFF_CDEF));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'h8, SIZE_WORD, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'h9, SIZE_HALF, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'h2, SIZE_WORD, 32'h0));
    send_word(make_access(KIND_WRITE, 1'b1, 1'b0, 32'hB, SIZE_HALF, 32'h0));
    send_word(make_access(KIND_WRITE, 1'b1, 1'b0, 32'h6, SIZE_WORD_ALT, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, MEM_BYTES - 1, SIZE_BYTE, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, MEM_BYTES, SIZE_WORD, 32'h0));
    send_word(make_access(KIND_WRITE, 1'b1, 1'b0, 32'hFFFF_FFFF, SIZE_WORD, 32'hFFFF_FFFF));
    send_word(make_access(KIND_WRITE, 1'b0, 1'b0, 32'h7, SIZE_HALF, 32'hFFFF_FFFF));
    send_word(make_access(KIND_WRITE, 1'b1, 1'b1, 32'h0, SIZE_WORD, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b1, 32'h0, SIZE_WORD, 32'h0));
    send_word(make_access(KIND_READ, 1'b1, 1'b0, 32'h0, SIZE_WORD, 32'h0));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_word(random_access());
    wait_for_results();
  endtask

  // Block the result side for a long stretch while words keep coming
  task automatic test_receiver_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 150;
    repeat (24) send_word(random_access());
    wait_for_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic(300, 0, 0);
    test_random_traffic(300, 65, 0);
    test_random_traffic(300, 0, 65);
    test_receiver_holdoff();
    test_random_traffic(300, 25, 25);
    if (expected_q.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_q.size());
    end
    $display("Sent %0d loads and stores, checked %0d results, %0d of them out of range,",
             words_sent, results_checked, faults_seen);
    $display("across free-running, idle, stalled and held-off traffic.");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
